// ----- rtl/hsks_pkg.sv -----
// shared types, constants and key compare for the heap sort block
package hsks_pkg;

    localparam int DATA_W          = 32;
    localparam int MAX_ENTRIES_DEF = 64;
    localparam int RESULT_LIMIT    = 64;
    localparam int IDX_W           = $clog2(RESULT_LIMIT + 1);
    localparam int KEEP_W          = 7;
    localparam logic [KEEP_W-1:0] KEEP_RESET = 7'd10;

    // apb register map
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_KEEP = 1'b0;

    typedef struct packed {
        logic signed [DATA_W-1:0] key;
        logic signed [DATA_W-1:0] second;
        logic signed [DATA_W-1:0] third;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // strict signed less-than on keys
    function automatic logic key_less(input logic signed [DATA_W-1:0] a,
                                      input logic signed [DATA_W-1:0] b);
        return a < b;
    endfunction

endpackage

// ----- rtl/hsks_ram.sv -----
// generic single write, single read ram with registered read data
module hsks_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/heap_sort_keep_smallest_top.sv -----
// top level: entry loader, heapsort sequencer over one ram, result emitter
//
// Collects entries of three signed Q16.16 words (key, second, third), one
// beat per clock, into a ram of MAX_ENTRIES rows until a beat marked
// last_entry arrives; entries beyond MAX_ENTRIES are dropped and flagged on
// overflow. The stored set is then heapsorted in ascending signed key order
// (max-heap built by sift-down, then root extraction) and the first
// min(count, keep_count, 64) entries are sent out, out_last on the final
// beat; a keep_count of zero sends nothing and just ends the set. A last
// beat holds the input off for the sort and the emission: each sift level
// reads the left child, reads the right child, then compares and moves;
// each build sift adds setup and write-back, and each extraction reads the
// root and the heap tail, writes the root to the tail and sifts the tail
// down from the top, over a ram with one read and one write port. Emission
// registers each sorted row before offering it and reads the next row only
// once out_ready takes the beat. keep_count sits at byte address 0 of the
// apb port and resets to 10; write it only while idle.
module heap_sort_keep_smallest_top #(
    parameter int MAX_ENTRIES = hsks_pkg::MAX_ENTRIES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // apb configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [hsks_pkg::PADDR_W-1:0]        paddr,
    input  logic [hsks_pkg::PDATA_W-1:0]        pwdata,
    output logic [hsks_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready,
    // input channel
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [hsks_pkg::DATA_W-1:0]  key_value,
    input  logic signed [hsks_pkg::DATA_W-1:0]  second_value,
    input  logic signed [hsks_pkg::DATA_W-1:0]  third_value,
    input  logic                                last_entry,
    // output channel
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [hsks_pkg::DATA_W-1:0]  out_key,
    output logic signed [hsks_pkg::DATA_W-1:0]  out_second,
    output logic signed [hsks_pkg::DATA_W-1:0]  out_third,
    output logic                                out_last,
    output logic                                overflow
);

    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int IW = hsks_pkg::IDX_W;
    localparam int MW = (CW > hsks_pkg::KEEP_W) ? CW : hsks_pkg::KEEP_W;

    // sequencer states
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_SIFT_RD  = 4'd1;   // read the node that sifts down
    localparam logic [3:0] S_SIFT_CUR = 4'd2;   // hold it, read left child
    localparam logic [3:0] S_KID1     = 4'd3;   // left child back, read right child
    localparam logic [3:0] S_KID2     = 4'd4;   // pick larger child
    localparam logic [3:0] S_DEC      = 4'd5;   // move child up or stop
    localparam logic [3:0] S_END      = 4'd6;   // write sifted entry into its hole
    localparam logic [3:0] S_X_ROOT   = 4'd7;   // extraction: read root
    localparam logic [3:0] S_X_TAKE   = 4'd8;   // hold root, read heap tail
    localparam logic [3:0] S_X_LAST   = 4'd9;   // root to tail, tail sifts from top
    localparam logic [3:0] S_E_START  = 4'd10;  // work out the beat count
    localparam logic [3:0] S_E_RD     = 4'd11;  // read first sorted row
    localparam logic [3:0] S_E_WAIT   = 4'd12;  // load output register
    localparam logic [3:0] S_E_HOLD   = 4'd13;  // wait for the beat to be taken

    logic [3:0]               state_reg, state_next;
    logic [CW-1:0]            count_reg, count_next;
    logic                     dropped_reg, dropped_next;
    logic                     extract_reg, extract_next;
    logic [hsks_pkg::KEEP_W-1:0] keep_reg;
    logic                     out_valid_reg, out_valid_next;

    // sort and emit working registers, no reset needed
    logic [AW-1:0]            node_reg, node_next;
    logic [AW-1:0]            bound_reg, bound_next;
    logic [AW-1:0]            top_reg, top_next;
    logic [AW-1:0]            kid_reg, kid_next;
    logic [AW-1:0]            pick_reg, pick_next;
    hsks_pkg::entry_t         cur_reg, cur_next;
    hsks_pkg::entry_t         best_reg, best_next;
    logic [IW-1:0]            idx_reg, idx_next;
    logic [IW-1:0]            emit_n_reg, emit_n_next;
    hsks_pkg::entry_t         out_data_reg, out_data_next;
    logic                     out_last_reg, out_last_next;
    logic                     overflow_reg, overflow_next;

    // ram port
    logic                     ram_we;
    logic [AW-1:0]            ram_waddr;
    hsks_pkg::entry_t         ram_wdata;
    logic [AW-1:0]            ram_raddr;
    hsks_pkg::entry_t         ram_rdata;

    logic                     in_fire;
    logic                     cfg_write;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    assign prdata = (paddr[2] == hsks_pkg::REG_KEEP) ? hsks_pkg::PDATA_W'(keep_reg) : '0;

    hsks_ram #(
        .WIDTH (hsks_pkg::ENTRY_W),
        .DEPTH (MAX_ENTRIES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        logic [CW-1:0] n_new;
        logic [CW-1:0] n_less2;
        logic [AW:0]   kid_ext;
        logic [AW:0]   kid1_ext;
        logic [AW:0]   bound_ext;
        logic [AW:0]   pkid_ext;
        logic [MW-1:0] cnt_m;
        logic [MW-1:0] keep_m;
        logic [MW-1:0] emit_m;

        state_next    = state_reg;
        count_next    = count_reg;
        dropped_next  = dropped_reg;
        extract_next  = extract_reg;
        out_valid_next = out_valid_reg;
        node_next     = node_reg;
        bound_next    = bound_reg;
        top_next      = top_reg;
        kid_next      = kid_reg;
        pick_next     = pick_reg;
        cur_next      = cur_reg;
        best_next     = best_reg;
        idx_next      = idx_reg;
        emit_n_next   = emit_n_reg;
        out_data_next = out_data_reg;
        out_last_next = out_last_reg;
        overflow_next = overflow_reg;

        ram_we    = 1'b0;
        ram_waddr = node_reg;
        ram_wdata = cur_reg;
        ram_raddr = '0;

        n_new     = count_reg;
        n_less2   = '0;
        bound_ext = {1'b0, bound_reg};
        kid_ext   = {node_reg, 1'b1};
        kid1_ext  = {1'b0, kid_reg} + (AW+1)'(1);
        pkid_ext  = {pick_reg, 1'b1};
        cnt_m     = MW'(count_reg);
        keep_m    = MW'(keep_reg);
        emit_m    = (cnt_m < keep_m) ? cnt_m : keep_m;
        if (emit_m > MW'(hsks_pkg::RESULT_LIMIT))
        begin
            emit_m = MW'(hsks_pkg::RESULT_LIMIT);
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (count_reg < CW'(MAX_ENTRIES))
                    begin
                        ram_we     = 1'b1;
                        ram_waddr  = AW'(count_reg);
                        ram_wdata  = '{key: key_value, second: second_value,
                                       third: third_value};
                        n_new      = count_reg + CW'(1);
                        count_next = n_new;
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                    if (last_entry)
                    begin
                        extract_next = 1'b0;
                        if (n_new < CW'(2))
                        begin
                            state_next = S_E_START;
                        end
                        else
                        begin
                            // last parent is (n-2)/2
                            n_less2    = n_new - CW'(2);
                            top_next   = AW'(n_less2 >> 1);
                            node_next  = AW'(n_less2 >> 1);
                            bound_next = AW'(n_new - CW'(1));
                            state_next = S_SIFT_RD;
                        end
                    end
                end
            end

            S_SIFT_RD:
            begin
                ram_raddr  = node_reg;
                state_next = S_SIFT_CUR;
            end

            S_SIFT_CUR:
            begin
                cur_next = ram_rdata;
                if (kid_ext <= bound_ext)
                begin
                    ram_raddr  = kid_ext[AW-1:0];
                    kid_next   = kid_ext[AW-1:0];
                    state_next = S_KID1;
                end
                else
                begin
                    state_next = S_END;
                end
            end

            S_KID1:
            begin
                best_next = ram_rdata;
                pick_next = kid_reg;
                if (kid1_ext <= bound_ext)
                begin
                    ram_raddr  = kid1_ext[AW-1:0];
                    state_next = S_KID2;
                end
                else
                begin
                    state_next = S_DEC;
                end
            end

            S_KID2:
            begin
                if (hsks_pkg::key_less(best_reg.key, ram_rdata.key))
                begin
                    best_next = ram_rdata;
                    pick_next = kid1_ext[AW-1:0];
                end
                state_next = S_DEC;
            end

            S_DEC:
            begin
                if (hsks_pkg::key_less(cur_reg.key, best_reg.key))
                begin
                    // larger child moves up into the hole
                    ram_we    = 1'b1;
                    ram_waddr = node_reg;
                    ram_wdata = best_reg;
                    node_next = pick_reg;
                    if (pkid_ext <= bound_ext)
                    begin
                        ram_raddr  = pkid_ext[AW-1:0];
                        kid_next   = pkid_ext[AW-1:0];
                        state_next = S_KID1;
                    end
                    else
                    begin
                        state_next = S_END;
                    end
                end
                else
                begin
                    state_next = S_END;
                end
            end

            S_END:
            begin
                ram_we    = 1'b1;
                ram_waddr = node_reg;
                ram_wdata = cur_reg;
                if (!extract_reg)
                begin
                    if (top_reg == '0)
                    begin
                        extract_next = 1'b1;
                        state_next   = S_X_ROOT;
                    end
                    else
                    begin
                        top_next   = top_reg - AW'(1);
                        node_next  = top_reg - AW'(1);
                        state_next = S_SIFT_RD;
                    end
                end
                else if (bound_reg == '0)
                begin
                    state_next = S_E_START;
                end
                else
                begin
                    state_next = S_X_ROOT;
                end
            end

            S_X_ROOT:
            begin
                ram_raddr  = '0;
                state_next = S_X_TAKE;
            end

            S_X_TAKE:
            begin
                best_next  = ram_rdata;
                ram_raddr  = bound_reg;
                state_next = S_X_LAST;
            end

            S_X_LAST:
            begin
                cur_next   = ram_rdata;
                ram_we     = 1'b1;
                ram_waddr  = bound_reg;
                ram_wdata  = best_reg;
                bound_next = bound_reg - AW'(1);
                node_next  = '0;
                if (bound_ext >= (AW+1)'(2))
                begin
                    ram_raddr  = AW'(1);
                    kid_next   = AW'(1);
                    state_next = S_KID1;
                end
                else
                begin
                    state_next = S_END;
                end
            end

            S_E_START:
            begin
                if (emit_m == '0)
                begin
                    count_next   = '0;
                    dropped_next = 1'b0;
                    state_next   = S_IDLE;
                end
                else
                begin
                    emit_n_next = IW'(emit_m);
                    idx_next    = '0;
                    state_next  = S_E_RD;
                end
            end

            S_E_RD:
            begin
                ram_raddr  = AW'(idx_reg);
                state_next = S_E_WAIT;
            end

            S_E_WAIT:
            begin
                out_data_next  = ram_rdata;
                out_last_next  = ((idx_reg + IW'(1)) == emit_n_reg);
                overflow_next  = dropped_reg;
                out_valid_next = 1'b1;
                state_next     = S_E_HOLD;
            end

            S_E_HOLD:
            begin
                if (out_ready)
                begin
                    out_valid_next = 1'b0;
                    if (out_last_reg)
                    begin
                        count_next   = '0;
                        dropped_next = 1'b0;
                        state_next   = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IW'(1);
                        ram_raddr  = AW'(idx_reg + IW'(1));
                        state_next = S_E_WAIT;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            dropped_reg   <= 1'b0;
            extract_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            keep_reg      <= hsks_pkg::KEEP_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            dropped_reg   <= dropped_next;
            extract_reg   <= extract_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write && (paddr[2] == hsks_pkg::REG_KEEP))
            begin
                keep_reg <= pwdata[hsks_pkg::KEEP_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg     <= node_next;
        bound_reg    <= bound_next;
        top_reg      <= top_next;
        kid_reg      <= kid_next;
        pick_reg     <= pick_next;
        cur_reg      <= cur_next;
        best_reg     <= best_next;
        idx_reg      <= idx_next;
        emit_n_reg   <= emit_n_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
        overflow_reg <= overflow_next;
    end

    // output beat register
    assign out_valid  = out_valid_reg;
    assign out_key    = out_data_reg.key;
    assign out_second = out_data_reg.second;
    assign out_third  = out_data_reg.third;
    assign out_last   = out_last_reg;
    assign overflow   = overflow_reg;

endmodule

// ----- rtl/hsks_checker.sv -----
// port level checks for the heap sort block, bound to the top level
module hsks_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic                                last_entry,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic signed [hsks_pkg::DATA_W-1:0]  out_key,
    input  logic signed [hsks_pkg::DATA_W-1:0]  out_second,
    input  logic signed [hsks_pkg::DATA_W-1:0]  out_third,
    input  logic                                out_last,
    input  logic                                overflow
);

    // no loading while a sorted beat is on offer
    a_no_load_while_emit: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input ready while an output beat is pending");

    // an entry that does not close the set leaves the loader ready
    a_load_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !last_entry) |=> in_ready)
        else $error("loader stalled after a plain entry");

    // after the closing beat of a run the block returns to loading
    a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && out_last) |=> (!out_valid && in_ready))
        else $error("block not idle after the final beat");

    // a stalled beat holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_key)
            && $stable(out_second) && $stable(out_third)
            && $stable(out_last) && $stable(overflow)))
        else $error("output beat changed while stalled");

endmodule

bind heap_sort_keep_smallest_top hsks_checker u_hsks_checker (.*);
